FILE: src/caw_pkg.sv
// Shared types and constants for the critical aperture window.
package caw_pkg;

  localparam int CAW_SAMPLE_BITS = 16;
  localparam int CAW_MAX_WINDOW  = 256;
  localparam int CAW_QUEUE_DEPTH = 2;
  localparam int CAW_FUNC_W      = 2;
  localparam int CAW_DX_W        = 8;
  localparam int CAW_X_W         = 16;
  localparam int CAW_EPS_W       = 16;
  localparam int CAW_SIZE_W      = 9;
  localparam int CAW_ADDR_W      = 3;
  localparam int CAW_OUT_W       = 16;

  typedef enum logic [CAW_FUNC_W-1:0] {
    FUNC_OPEN   = 2'd0,
    FUNC_NODATA = 2'd1,
    FUNC_OFFER  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // register selector taken from paddr bit 2
  localparam logic REG_EPSILON   = 1'b0;
  localparam logic REG_WIN_LIMIT = 1'b1;

  typedef struct packed {
    logic [CAW_EPS_W-1:0]  epsilon;
    logic [CAW_SIZE_W-1:0] eff_size;
  } cfg_t;

  // first field sits in the highest bits
  typedef struct packed {
    logic                  no_data;
    logic                  is_empty;
    logic                  is_full;
    logic [CAW_SIZE_W-1:0] window_length;
    logic                  accepted;
  } res_t;

endpackage

FILE: src/caw_queue.sv
// Small flop-based FIFO between the decode front and the execute back.
module caw_queue #(
  parameter int W     = 26,
  parameter int DEPTH = caw_pkg::CAW_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic         rd_valid,
  output logic [W-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");
`endif

endmodule

FILE: src/caw_front.sv
// Input side: accepts beats, decodes the function code and clamps the x step.
module caw_front #(
  parameter int SAMPLE_BITS = caw_pkg::CAW_SAMPLE_BITS,
  parameter int QDEPTH      = caw_pkg::CAW_QUEUE_DEPTH,
  localparam int TDATA_W    = ((caw_pkg::CAW_DX_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [TDATA_W-1:0]            in_tdata,
  input  logic [caw_pkg::CAW_FUNC_W-1:0] in_tuser,
  output logic                          q_valid,
  input  logic                          q_pop,
  output caw_pkg::func_t                q_op,
  output logic [caw_pkg::CAW_DX_W-1:0]  q_dx,
  output logic [SAMPLE_BITS-1:0]        q_y
);
  import caw_pkg::*;

  localparam int EW = CAW_FUNC_W + CAW_DX_W + SAMPLE_BITS;

  logic                  q_full;
  logic                  push;
  logic [CAW_DX_W-1:0]   dx_raw;
  logic [CAW_DX_W-1:0]   dx_fix;
  func_t                 op;
  logic [EW-1:0]         wr_entry;
  logic [EW-1:0]         rd_entry;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  assign op     = func_t'(in_tuser);
  assign dx_raw = in_tdata[CAW_DX_W-1:0];
  // a zero step counts as one so every line keeps a positive run
  assign dx_fix = (dx_raw == '0) ? CAW_DX_W'(1) : dx_raw;

  assign wr_entry = {op, dx_fix, in_tdata[CAW_DX_W +: SAMPLE_BITS]};

  caw_queue #(
    .W     (EW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (rd_entry)
  );

  assign q_op = func_t'(rd_entry[EW-1 -: CAW_FUNC_W]);
  assign q_dx = rd_entry[SAMPLE_BITS +: CAW_DX_W];
  assign q_y  = rd_entry[SAMPLE_BITS-1:0];

endmodule

FILE: src/caw_back.sv
// Execute side: window state, aperture line compares and the result register.
module caw_back #(
  parameter int SAMPLE_BITS = caw_pkg::CAW_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  caw_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  caw_pkg::func_t               q_op,
  input  logic [caw_pkg::CAW_DX_W-1:0] q_dx,
  input  logic [SAMPLE_BITS-1:0]       q_y,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output caw_pkg::res_t                out_res
);
  import caw_pkg::*;

  localparam int DW  = SAMPLE_BITS + 1;
  localparam int RW  = ((DW > CAW_X_W + 1) ? DW : CAW_X_W + 1) + 1;
  localparam int PW  = RW + CAW_X_W + 1;
  localparam int SW  = CAW_SIZE_W;

  // window state
  logic                          nodata_r, nodata_nxt;
  logic [SW-1:0]                 count_r, count_nxt;
  logic signed [SAMPLE_BITS-1:0] anchor_r, anchor_nxt;
  logic [CAW_X_W-1:0]            x_r, x_nxt;
  logic [CAW_X_W-1:0]            lrun_r, lrun_nxt;
  logic signed [RW-1:0]          lrise_r, lrise_nxt;
  logic [CAW_X_W-1:0]            urun_r, urun_nxt;
  logic signed [RW-1:0]          urise_r, urise_nxt;

  logic                          out_valid_r;
  res_t                          res_r, res_nxt;

  logic [CAW_X_W:0]              nx_sum;
  logic [CAW_X_W-1:0]            nx;
  logic signed [CAW_X_W:0]       nx_s, lrun_s, urun_s;
  logic signed [DW-1:0]          d;
  logic signed [RW-1:0]          d_w, eps_w, dl, du;
  logic signed [PW-1:0]          p_d_l, p_d_u, p_lr_nx, p_ur_nx, p_dl_l, p_du_u;
  logic                          below, above, tight_l, tight_u;
  logic                          can_take, acc;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // saturate x at the top of its range
  assign nx_sum = {1'b0, x_r} + (CAW_X_W + 1)'(q_dx);
  assign nx     = nx_sum[CAW_X_W] ? '1 : nx_sum[CAW_X_W-1:0];

  assign nx_s   = $signed({1'b0, nx});
  assign lrun_s = $signed({1'b0, lrun_r});
  assign urun_s = $signed({1'b0, urun_r});

  assign d     = $signed({q_y[SAMPLE_BITS-1], q_y}) - $signed({anchor_r[SAMPLE_BITS-1], anchor_r});
  assign d_w   = {{(RW - DW){d[DW-1]}}, d};
  assign eps_w = $signed({{(RW - CAW_EPS_W){1'b0}}, cfg.epsilon});
  assign dl    = d_w - eps_w;
  assign du    = d_w + eps_w;

  // six independent products, shared between the accept and narrowing compares
  assign p_d_l   = d_w * lrun_s;
  assign p_d_u   = d_w * urun_s;
  assign p_lr_nx = lrise_r * nx_s;
  assign p_ur_nx = urise_r * nx_s;
  assign p_dl_l  = dl * lrun_s;
  assign p_du_u  = du * urun_s;

  assign below   = p_d_l < p_lr_nx;
  assign above   = p_d_u > p_ur_nx;
  assign tight_l = p_dl_l > p_lr_nx;
  assign tight_u = p_du_u < p_ur_nx;

  assign can_take = !nodata_r && (count_r < cfg.eff_size);

  always_comb begin
    nodata_nxt = nodata_r;
    count_nxt  = count_r;
    anchor_nxt = anchor_r;
    x_nxt      = x_r;
    lrun_nxt   = lrun_r;
    lrise_nxt  = lrise_r;
    urun_nxt   = urun_r;
    urise_nxt  = urise_r;
    acc        = 1'b0;
    case (q_op)
      FUNC_OPEN: begin
        nodata_nxt = 1'b0;
        count_nxt  = '0;
        anchor_nxt = q_y;
        x_nxt      = '0;
      end
      FUNC_NODATA: begin
        nodata_nxt = 1'b1;
        count_nxt  = SW'(1);
      end
      FUNC_OFFER: begin
        if (can_take) begin
          if (count_r == '0) begin
            lrun_nxt  = nx;
            lrise_nxt = dl;
            urun_nxt  = nx;
            urise_nxt = du;
            acc       = 1'b1;
          end else if (!below && !above) begin
            if (tight_l) begin
              lrun_nxt  = nx;
              lrise_nxt = dl;
            end
            if (tight_u) begin
              urun_nxt  = nx;
              urise_nxt = du;
            end
            acc = 1'b1;
          end
          if (acc) begin
            count_nxt = count_r + 1'b1;
            x_nxt     = nx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.accepted      = acc;
    res_nxt.window_length = count_nxt;
    res_nxt.is_full       = (count_nxt >= cfg.eff_size);
    res_nxt.is_empty      = (count_nxt == '0);
    res_nxt.no_data       = nodata_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodata_r    <= 1'b1;
      count_r     <= SW'(1);
      anchor_r    <= '0;
      x_r         <= '0;
      lrun_r      <= '0;
      lrise_r     <= '0;
      urun_r      <= '0;
      urise_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        nodata_r    <= nodata_nxt;
        count_r     <= count_nxt;
        anchor_r    <= anchor_nxt;
        x_r         <= x_nxt;
        lrun_r      <= lrun_nxt;
        lrise_r     <= lrise_nxt;
        urun_r      <= urun_nxt;
        urise_r     <= urise_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

`ifndef SYNTH
  a_nodata_count: assert property (@(posedge clk) disable iff (!rst_n)
    nodata_r |-> count_r == SW'(1))
    else $error("no-data window with count other than one");
  a_x_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && acc |=> x_r >= $past(x_r))
    else $error("x moved backward on an accepted sample");
  a_non_offer_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (q_op != FUNC_OFFER) |=> !res_r.accepted)
    else $error("non-offer beat reported as accepted");
  a_accept_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && acc |=> !nodata_r && count_r != '0)
    else $error("accepted sample left window empty or no-data");
`endif

endmodule

FILE: src/critical_aperture_window.sv
// Top level of the critical aperture (swing-door) compression window.
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid/in_tready     tdata x_delta, sample_value; tuser func
//   out_     out  out_tvalid/out_tready   tdata accepted .. no_data
//   cfg_     in   APB psel/penable        epsilon @0x0, window limit @0x4
//
// One beat per cycle sustained while out_tready stays high; an input beat is held in
// a queue entry, then executed into the result register.
// The execute step updates the aperture lines from six parallel products,
// and the next beat depends on those lines.
// The two-entry queue decouples input from output stalls; a held result does
// not stop the queue from filling.
// Synchronous active-low reset; window starts as a no-data window with count one.
module critical_aperture_window #(
  parameter int SAMPLE_BITS = caw_pkg::CAW_SAMPLE_BITS,
  localparam int TDATA_W    = ((caw_pkg::CAW_DX_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] x_delta, [SAMPLE_BITS+7:8] sample_value, zero fill above
  input  logic [TDATA_W-1:0]             in_tdata,
  // [1:0] func
  input  logic [caw_pkg::CAW_FUNC_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] accepted, [9:1] window_length, [10] is_full, [11] is_empty, [12] no_data
  output logic [caw_pkg::CAW_OUT_W-1:0]  out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [caw_pkg::CAW_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import caw_pkg::*;

  localparam int RES_W = $bits(res_t);

  logic [CAW_EPS_W-1:0]  eps_r;
  logic [CAW_SIZE_W-1:0] wsize_r;
  logic                  cfg_wr;
  logic                  reg_sel;
  cfg_t                  cfg;

  logic                  q_valid, q_pop;
  func_t                 q_op;
  logic [CAW_DX_W-1:0]   q_dx;
  logic [SAMPLE_BITS-1:0] q_y;
  res_t                  out_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r   <= '0;
      wsize_r <= CAW_SIZE_W'(256);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_EPSILON:   eps_r   <= cfg_pwdata[CAW_EPS_W-1:0];
        REG_WIN_LIMIT: wsize_r <= cfg_pwdata[CAW_SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EPSILON:   cfg_prdata = {{(32 - CAW_EPS_W){1'b0}}, eps_r};
      REG_WIN_LIMIT: cfg_prdata = {{(32 - CAW_SIZE_W){1'b0}}, wsize_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // zero size acts as one, oversize clamps to the largest window
  always_comb begin
    cfg.epsilon = eps_r;
    if (wsize_r == '0) begin
      cfg.eff_size = CAW_SIZE_W'(1);
    end else if (32'(wsize_r) > 32'(CAW_MAX_WINDOW)) begin
      cfg.eff_size = CAW_SIZE_W'(CAW_MAX_WINDOW);
    end else begin
      cfg.eff_size = wsize_r;
    end
  end

  caw_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .QDEPTH      (CAW_QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (q_op),
    .q_dx      (q_dx),
    .q_y       (q_y)
  );

  caw_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_op       (q_op),
    .q_dx       (q_dx),
    .q_y        (q_y),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {{(CAW_OUT_W - RES_W){1'b0}}, out_res};

endmodule

FILE: dv/critical_aperture_window_tb.sv
// Self-checking stream testbench for the critical aperture window: predicts each result beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import caw_pkg::*;

  localparam logic [CAW_ADDR_W-1:0] ADDR_EPSILON   = {REG_EPSILON, 2'b00};
  localparam logic [CAW_ADDR_W-1:0] ADDR_WIN_LIMIT = {REG_WIN_LIMIT, 2'b00};

  typedef struct packed {
    func_t              func;
    logic [7:0]         dx;
    logic signed [15:0] level;
  } offer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [7:0] x_delta, [23:8] sample_value
  logic [23:0] in_tdata = '0;
  // [1:0] func
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] accepted, [9:1] window_length, [10] is_full, [11] is_empty, [12] no_data
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  critical_aperture_window dut (.*);

  always #5 clk = ~clk;

  // window state as the block should hold it
  logic [15:0]  eps_reg = 16'd0;
  logic [8:0]   size_reg = 9'd256;
  logic         win_nodata = 1'b1;
  logic [8:0]   win_count = 9'd1;
  longint       anchor = 0;
  int unsigned  cur_x = 0;
  longint       lo_run = 0, lo_rise = 0, hi_run = 0, hi_rise = 0;

  offer_t pending_offers[$];
  res_t   expected_results[$];
  offer_t beat_on_bus;
  int     idle_odds = 0;
  int     tx_gap = 0;
  int     rx_stall = 0;
  int     errors = 0;
  int     result_idx = 0;

  function automatic res_t aperture_step(input offer_t b);
    longint      y, d, e, nx, lo_d, hi_d;
    int unsigned eff, step, nxu;
    logic        took;
    res_t        r;
    eff = (size_reg == 0) ? 1 : (size_reg > CAW_MAX_WINDOW) ? CAW_MAX_WINDOW : size_reg;
    y = longint'($signed(b.level));
    e = longint'(eps_reg);
    step = (b.dx == 0) ? 1 : b.dx;
    took = 1'b0;
    case (b.func)
      FUNC_OPEN: begin
        win_nodata = 1'b0;
        win_count = '0;
        anchor = y;
        cur_x = 0;
      end
      FUNC_NODATA: begin
        win_nodata = 1'b1;
        win_count = 9'd1;
      end
      FUNC_OFFER: begin
        if (!win_nodata && win_count < eff) begin
          nxu = cur_x + step;
          if (nxu > 65535) nxu = 65535;
          nx = longint'(nxu);
          d = y - anchor;
          lo_d = d - e;
          hi_d = d + e;
          if (win_count == 0) begin
            lo_run = nx;
            lo_rise = lo_d;
            hi_run = nx;
            hi_rise = hi_d;
            took = 1'b1;
          end else if (!(d * lo_run < lo_rise * nx) && !(d * hi_run > hi_rise * nx)) begin
            // narrow each line only when the new one is tighter
            if (lo_d * lo_run > lo_rise * nx) begin
              lo_run = nx;
              lo_rise = lo_d;
            end
            if (hi_d * hi_run < hi_rise * nx) begin
              hi_run = nx;
              hi_rise = hi_d;
            end
            took = 1'b1;
          end
          if (took) begin
            win_count = win_count + 9'd1;
            cur_x = nxu;
          end
        end
      end
      default: ;
    endcase
    r.accepted = took;
    r.window_length = win_count;
    r.is_full = (win_count >= eff);
    r.is_empty = (win_count == 0);
    r.no_data = win_nodata;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(aperture_step(beat_on_bus));
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_offers.size() != 0) begin
          beat_on_bus = pending_offers.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {beat_on_bus.level, beat_on_bus.dx};
          in_tuser <= beat_on_bus.func;
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) tx_gap = $urandom_range(1, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[12:0]);
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result beat %h with nothing expected", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted || got.window_length !== want.window_length ||
              got.is_full !== want.is_full || got.is_empty !== want.is_empty ||
              got.no_data !== want.no_data)
            flag_error($sformatf({"result %0d: expected acc %b len %0d full %b empty %b ",
                                  "nodata %b, got acc %b len %0d full %b empty %b nodata %b"},
                                 result_idx, want.accepted, want.window_length, want.is_full,
                                 want.is_empty, want.no_data, got.accepted, got.window_length,
                                 got.is_full, got.is_empty, got.no_data));
          result_idx++;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        rx_stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_beat(input func_t f, input logic [7:0] dx, input logic [15:0] lvl);
    offer_t b;
    b.func = f;
    b.dx = dx;
    b.level = lvl;
    pending_offers.push_back(b);
  endtask

  task automatic write_reg(input logic [2:0] addr, input int unsigned data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_EPSILON) eps_reg = data[15:0];
    else size_reg = data[8:0];
  endtask

  task automatic wait_settled();
    while (pending_offers.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // mostly windows of samples near a sloped line, with noise and broken runs mixed in
  task automatic push_random(input int n);
    int left, a, s, x, m, v, k, runlen, dx;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        push_beat(func_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
        left--;
      end else begin
        a = int'($urandom_range(0, 65535)) - 32768;
        s = int'($urandom_range(0, 64)) - 32;
        m = int'(eps_reg) + 2;
        x = 0;
        if ($urandom_range(0, 9) == 0) push_beat(FUNC_NODATA, 8'($urandom), 16'($urandom));
        else push_beat(FUNC_OPEN, 8'($urandom), 16'(a));
        left--;
        runlen = $urandom_range(1, 40);
        for (k = 0; k < runlen && left > 0; k++) begin
          dx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12);
          x += (dx == 0) ? 1 : dx;
          v = a + (s * x) / 16;
          if (k % 3 == 0) v += int'($urandom_range(0, 2 * m)) - m;
          else v += int'($urandom_range(0, m / 2)) - m / 4;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          push_beat(FUNC_OFFER, 8'(dx), 16'(v));
          left--;
        end
      end
    end
  endtask

  initial begin
    int unsigned eps, wsz;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: zero aperture, full-size window, starts as no-data
    idle_odds = 3;
    push_beat(FUNC_OFFER, 8'd1, 16'sd5);
    push_beat(FUNC_NOP, 8'hFF, 16'h8000);
    push_beat(FUNC_OPEN, 8'd0, 16'h8000);
    push_beat(FUNC_OFFER, 8'd0, 16'h7FFF);
    push_beat(FUNC_OFFER, 8'd255, 16'h7FFF);
    push_beat(FUNC_OPEN, 8'hFF, 16'd0);
    push_beat(FUNC_OFFER, 8'd1, 16'd1);
    push_beat(FUNC_OFFER, 8'd1, 16'd2);
    push_beat(FUNC_OFFER, 8'd1, 16'd3);
    push_beat(FUNC_OFFER, 8'd1, 16'd5);
    push_beat(FUNC_OFFER, 8'd1, 16'd2);
    push_beat(FUNC_NODATA, 8'hAA, 16'h5555);
    push_beat(FUNC_OFFER, 8'h55, 16'hAAAA);
    push_beat(FUNC_OPEN, 8'd3, 16'h7FFF);
    push_beat(FUNC_OFFER, 8'd128, 16'h8000);
    wait_settled();

    // widest aperture, two-sample window: fill it, then offer to a full window
    write_reg(ADDR_EPSILON, 65535);
    write_reg(ADDR_WIN_LIMIT, 2);
    push_beat(FUNC_OPEN, 8'd7, 16'd0);
    push_beat(FUNC_OFFER, 8'd200, 16'h7FFF);
    push_beat(FUNC_OFFER, 8'd55, 16'h8000);
    push_beat(FUNC_OFFER, 8'd1, 16'd0);
    push_beat(FUNC_NOP, 8'd0, 16'd0);
    wait_settled();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin eps = $urandom_range(0, 64);    wsz = 256; idle_odds = 4; end
        1: begin eps = 0;                        wsz = 1;   idle_odds = 0; end
        2: begin eps = 65535;                    wsz = 511; idle_odds = 3; end
        3: begin eps = $urandom_range(1, 300);   wsz = 0;   idle_odds = 5; end
        4: begin eps = $urandom_range(0, 2000);  wsz = $urandom_range(2, 40); idle_odds = 2; end
        default: begin eps = $urandom_range(0, 500); wsz = $urandom_range(2, 12); idle_odds = 0; end
      endcase
      write_reg(ADDR_EPSILON, eps);
      write_reg(ADDR_WIN_LIMIT, wsz);
      push_random(75);
      wait_settled();
    end

    repeat (4) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS critical_aperture_window");
    end else begin
      $display("FAIL critical_aperture_window");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL critical_aperture_window");
    $finish;
  end

endmodule
